// ===== sv/gost_pkg.sv =====
// shared constants and round functions for the gost block cipher
`timescale 1ns / 1ps
`default_nettype none

package gost_pkg;

  localparam int Rounds   = 32;
  localparam int KeyWords = 8;
  localparam int WordW    = 32;
  localparam int KeyIdxW  = $clog2(KeyWords);
  localparam int RoundW   = $clog2(Rounds);
  localparam int RotLeft  = 11;

  // round at which the key order turns around, per direction
  localparam logic [RoundW-1:0] EncTurn = RoundW'(24);
  localparam logic [RoundW-1:0] DecTurn = RoundW'(8);

  localparam logic [3:0] SBOX [KeyWords][16] = '{
    '{4'd4,  4'd10, 4'd9,  4'd2,  4'd13, 4'd8,  4'd0,  4'd14,
      4'd6,  4'd11, 4'd1,  4'd12, 4'd7,  4'd15, 4'd5,  4'd3},
    '{4'd14, 4'd11, 4'd4,  4'd12, 4'd6,  4'd13, 4'd15, 4'd10,
      4'd2,  4'd3,  4'd8,  4'd1,  4'd0,  4'd7,  4'd5,  4'd9},
    '{4'd5,  4'd8,  4'd1,  4'd13, 4'd10, 4'd3,  4'd4,  4'd2,
      4'd14, 4'd15, 4'd12, 4'd7,  4'd6,  4'd0,  4'd9,  4'd11},
    '{4'd7,  4'd13, 4'd10, 4'd1,  4'd0,  4'd8,  4'd9,  4'd15,
      4'd14, 4'd4,  4'd6,  4'd12, 4'd11, 4'd2,  4'd5,  4'd3},
    '{4'd6,  4'd12, 4'd7,  4'd1,  4'd5,  4'd15, 4'd13, 4'd8,
      4'd4,  4'd10, 4'd9,  4'd14, 4'd0,  4'd3,  4'd11, 4'd2},
    '{4'd4,  4'd11, 4'd10, 4'd0,  4'd7,  4'd2,  4'd1,  4'd13,
      4'd3,  4'd6,  4'd8,  4'd5,  4'd9,  4'd12, 4'd15, 4'd14},
    '{4'd13, 4'd11, 4'd4,  4'd1,  4'd3,  4'd15, 4'd5,  4'd9,
      4'd0,  4'd10, 4'd14, 4'd7,  4'd6,  4'd8,  4'd2,  4'd12},
    '{4'd1,  4'd15, 4'd13, 4'd0,  4'd5,  4'd7,  4'd10, 4'd4,
      4'd9,  4'd2,  4'd3,  4'd14, 4'd6,  4'd11, 4'd8,  4'd12}
  };

  // s-box substitution of all eight nibbles, then rotate left
  function automatic logic [WordW-1:0] round_fn(input logic [WordW-1:0] x);
    logic [WordW-1:0] s;
    s = '0;
    for (int n = 0; n < KeyWords; n++) begin
      s[4*n +: 4] = SBOX[n][x[4*n +: 4]];
    end
    return {s[WordW-RotLeft-1:0], s[WordW-1:WordW-RotLeft]};
  endfunction

  // key word used by a round: ascending before the turn, descending after
  function automatic logic [KeyIdxW-1:0] key_idx(input logic [RoundW-1:0] rnd,
                                                  input logic decrypt);
    logic ascending;
    ascending = decrypt ? (rnd < DecTurn) : (rnd < EncTurn);
    return ascending ? rnd[KeyIdxW-1:0] : ~rnd[KeyIdxW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/gost_block_cipher_ecb.sv =====
// gost 28147-89 ecb block cipher, one round per pipeline stage
// path: one input register, then 32 round stages, one add/s-box/xor each
// throughput: one item per cycle; busy is low except during and just after reset
// reset: synchronous, active high; clears the key words to zero and empties the pipeline
// results cannot be held off: done marks each result for exactly one cycle
`timescale 1ns / 1ps
`default_nettype none

module gost_block_cipher_ecb import gost_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // item input
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 action,
  input  wire logic [WordW-1:0]     left_word,
  input  wire logic [WordW-1:0]     right_word,
  // result output
  output logic                      done,
  output logic [WordW-1:0]          left_result,
  output logic [WordW-1:0]          right_result,
  // key word write channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [KeyIdxW-1:0]   cfg_index,
  input  wire logic [WordW-1:0]     cfg_data
);

  // key word registers; the user must write them only while no item is in flight (not enforced)
  logic [WordW-1:0] key [KeyWords];

  // pipeline: stage 0 is the input register, stage n+1 holds the block after round n
  logic             valid [Rounds+1];
  logic             dec   [Rounds+1];
  logic [WordW-1:0] lw    [Rounds+1];
  logic [WordW-1:0] rw    [Rounds+1];

  logic accept;

  // the pipeline never stalls, so the block only holds off items during and just after reset
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < KeyWords; i++) begin
        key[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      key[cfg_index] <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else begin
      valid[0] <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dec[0] <= action;
      lw[0]  <= left_word;
      rw[0]  <= right_word;
    end
  end

  // 32 round stages; the key word per stage is fixed but for the direction bit
  for (genvar s = 0; s < Rounds; s++) begin : g_round
    localparam logic [RoundW-1:0] Rnd = RoundW'(s);

    logic [KeyIdxW-1:0] kidx;
    logic [WordW-1:0]   sum;
    logic [WordW-1:0]   mixed;

    assign kidx  = key_idx(Rnd, dec[s]);
    assign sum   = lw[s] + key[kidx];
    assign mixed = round_fn(sum) ^ rw[s];

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[s+1] <= 1'b0;
      end else begin
        valid[s+1] <= valid[s];
      end
    end

    // payload follows the valid bit; idle stages just hold
    always_ff @(posedge clk) begin
      if (valid[s]) begin
        dec[s+1] <= dec[s];
        lw[s+1]  <= mixed;
        rw[s+1]  <= lw[s];
      end
    end
  end

  // final half swap happens in the port wiring
  assign done         = valid[Rounds];
  assign left_result  = rw[Rounds];
  assign right_result = lw[Rounds];

  // a result only comes out of an accepted item that has passed the input register and every round stage
  a_done_has_item: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, Rounds+1))
    else $error("result without a matching accepted item");

  // reset empties the whole pipeline
  a_reset_flushes: assert property (@(posedge clk)
    rst |=> !done && !valid[0])
    else $error("pipeline not empty after reset");

  // a key write reaches exactly the addressed word
  a_key_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> key[$past(cfg_index)] == $past(cfg_data))
    else $error("key word write lost");

endmodule

`default_nettype wire

// ===== test/tb_gost_block_cipher_ecb.sv =====
// self-checking testbench for the gost 28147-89 ecb block cipher pipeline
`timescale 1ns / 1ps

module tb_gost_block_cipher_ecb;
  import gost_pkg::*;

  // round at which the key word order turns from ascending to descending
  localparam int EncTurnRound = 24;
  localparam int DecTurnRound = 8;

  // own copy of the substitution table, nibble 0 uses row 0
  localparam logic [3:0] SubstTable [KeyWords][16] = '{
    '{4'd4,  4'd10, 4'd9,  4'd2,  4'd13, 4'd8,  4'd0,  4'd14,
      4'd6,  4'd11, 4'd1,  4'd12, 4'd7,  4'd15, 4'd5,  4'd3},
    '{4'd14, 4'd11, 4'd4,  4'd12, 4'd6,  4'd13, 4'd15, 4'd10,
      4'd2,  4'd3,  4'd8,  4'd1,  4'd0,  4'd7,  4'd5,  4'd9},
    '{4'd5,  4'd8,  4'd1,  4'd13, 4'd10, 4'd3,  4'd4,  4'd2,
      4'd14, 4'd15, 4'd12, 4'd7,  4'd6,  4'd0,  4'd9,  4'd11},
    '{4'd7,  4'd13, 4'd10, 4'd1,  4'd0,  4'd8,  4'd9,  4'd15,
      4'd14, 4'd4,  4'd6,  4'd12, 4'd11, 4'd2,  4'd5,  4'd3},
    '{4'd6,  4'd12, 4'd7,  4'd1,  4'd5,  4'd15, 4'd13, 4'd8,
      4'd4,  4'd10, 4'd9,  4'd14, 4'd0,  4'd3,  4'd11, 4'd2},
    '{4'd4,  4'd11, 4'd10, 4'd0,  4'd7,  4'd2,  4'd1,  4'd13,
      4'd3,  4'd6,  4'd8,  4'd5,  4'd9,  4'd12, 4'd15, 4'd14},
    '{4'd13, 4'd11, 4'd4,  4'd1,  4'd3,  4'd15, 4'd5,  4'd9,
      4'd0,  4'd10, 4'd14, 4'd7,  4'd6,  4'd8,  4'd2,  4'd12},
    '{4'd1,  4'd15, 4'd13, 4'd0,  4'd5,  4'd7,  4'd10, 4'd4,
      4'd9,  4'd2,  4'd3,  4'd14, 4'd6,  4'd11, 4'd8,  4'd12}
  };

  // ways of filling the eight key words
  typedef enum int {
    KEYS_ZERO,
    KEYS_ONES,
    KEYS_RANDOM,
    KEYS_ALTERNATE,
    KEYS_ONE_HOT
  } key_set_t;

  typedef struct packed {
    logic [WordW-1:0] left;
    logic [WordW-1:0] right;
  } block_t;

  typedef struct packed {
    logic   decrypt;
    block_t data;
  } block_item_t;

  localparam int RandomSegments = 8;
  localparam int SegmentItems   = 250;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // item input side
  logic             start      = 1'b0;
  logic             action     = 1'b0;
  logic [WordW-1:0] left_word  = '0;
  logic [WordW-1:0] right_word = '0;
  logic             busy;

  // result side
  logic             done;
  logic [WordW-1:0] left_result;
  logic [WordW-1:0] right_result;

  // key word write channel
  logic               cfg_valid = 1'b0;
  logic [KeyIdxW-1:0] cfg_index = '0;
  logic [WordW-1:0]   cfg_data  = '0;
  logic               cfg_ready;

  // blocks waiting to be sent and ciphertext/plaintext still to come back
  block_item_t pending_blocks [$];
  block_t      expected_blocks [$];
  block_item_t next_block;
  block_t      wanted_block;

  // key words as the block should hold them
  logic [WordW-1:0] key_copy [KeyWords];

  int send_idle_pct = 0;
  int fail_count    = 0;

  gost_block_cipher_ecb dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .action       (action),
    .left_word    (left_word),
    .right_word   (right_word),
    .done         (done),
    .left_result  (left_result),
    .right_result (right_result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // key word used by a round: ascending before the turn, descending after
  function automatic int key_for_round(input int rnd, input logic decrypt);
    int turn;
    turn = decrypt ? DecTurnRound : EncTurnRound;
    return (rnd < turn) ? (rnd % KeyWords) : (KeyWords - 1 - (rnd % KeyWords));
  endfunction

  // full 32-round feistel network with the final half swap
  function automatic block_t cipher_block(input logic decrypt,
                                          input logic [WordW-1:0] l_in,
                                          input logic [WordW-1:0] r_in);
    logic [WordW-1:0] l;
    logic [WordW-1:0] r;
    logic [WordW-1:0] sum;
    logic [WordW-1:0] subst;
    logic [WordW-1:0] mixed;
    block_t           res;
    l = l_in;
    r = r_in;
    for (int i = 0; i < Rounds; i++) begin
      // add modulo 2^32, wraps naturally at the word width
      sum = l + key_copy[key_for_round(i, decrypt)];
      for (int n = 0; n < KeyWords; n++) begin
        subst[4*n +: 4] = SubstTable[n][sum[4*n +: 4]];
      end
      mixed = {subst[WordW-RotLeft-1:0], subst[WordW-1:WordW-RotLeft]} ^ r;
      r = l;
      l = mixed;
    end
    // halves swapped once more after the last round
    res.left  = r;
    res.right = l;
    return res;
  endfunction

  function automatic logic [WordW-1:0] key_pattern(input key_set_t kind, input int idx);
    case (kind)
      KEYS_ZERO:      return '0;
      KEYS_ONES:      return '1;
      KEYS_ALTERNATE: return (idx % 2 == 0) ? '1 : '0;
      KEYS_ONE_HOT:   return WordW'(1) << (idx * 4 + $urandom_range(3));
      default:        return $urandom;
    endcase
  endfunction

  // mostly uniform words, sometimes an edge value
  function automatic logic [WordW-1:0] pick_word();
    int          roll;
    int unsigned bit_pos;
    roll    = $urandom_range(99);
    bit_pos = $urandom_range(WordW - 1);
    if (roll < 80) return $urandom;
    else if (roll < 85) return '0;
    else if (roll < 90) return '1;
    else if (roll < 95) return WordW'(1) << bit_pos;
    else return ~(WordW'(1) << bit_pos);
  endfunction

  task automatic add_block(input logic decrypt, input logic [WordW-1:0] l,
                           input logic [WordW-1:0] r);
    block_item_t it;
    it.decrypt    = decrypt;
    it.data.left  = l;
    it.data.right = r;
    pending_blocks.push_back(it);
  endtask

  // one write on the key channel, held until the block takes it
  task automatic write_key_word(input int idx, input logic [WordW-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= KeyIdxW'(idx);
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    key_copy[idx] = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic load_key_set(input key_set_t kind);
    for (int i = 0; i < KeyWords; i++) begin
      write_key_word(i, key_pattern(kind, i));
    end
  endtask

  // nothing queued, nothing in flight, then let the pipeline drain
  task automatic wait_drained();
    @(negedge clk);
    while (pending_blocks.size() != 0 || start || expected_blocks.size() != 0) begin
      @(negedge clk);
    end
    repeat (Rounds + 4) @(posedge clk);
  endtask

  // edges of the fields, both directions, and an encrypt/decrypt round trip
  task automatic add_directed_blocks();
    block_t ct;
    add_block(1'b0, '0, '0);
    add_block(1'b1, '0, '0);
    add_block(1'b0, '1, '1);
    add_block(1'b1, '1, '1);
    add_block(1'b0, 32'haaaa_aaaa, 32'h5555_5555);
    add_block(1'b1, 32'h5555_5555, 32'haaaa_aaaa);
    add_block(1'b0, 32'h0000_0001, 32'h8000_0000);
    add_block(1'b1, 32'h8000_0000, 32'h0000_0001);
    // decrypting a ciphertext gives the plaintext back, and the other way round
    ct = cipher_block(1'b0, 32'h0123_4567, 32'h89ab_cdef);
    add_block(1'b1, ct.left, ct.right);
    ct = cipher_block(1'b1, 32'hfedc_ba98, 32'h7654_3210);
    add_block(1'b0, ct.left, ct.right);
  endtask

  // driver: holds an item on the ports until it is taken
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      // item accepted at this edge, its result is due later
      if (start && !busy) begin
        expected_blocks.push_back(cipher_block(action, left_word, right_word));
      end
      if (!start || !busy) begin
        if (pending_blocks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_block = pending_blocks.pop_front();
          start      <= 1'b1;
          action     <= next_block.decrypt;
          left_word  <= next_block.data.left;
          right_word <= next_block.data.right;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every done cycle carries one result for the oldest item
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_blocks.size() == 0) begin
        $error("result with no item outstanding: left_result %h right_result %h",
               left_result, right_result);
        fail_count++;
      end else begin
        wanted_block = expected_blocks.pop_front();
        if (left_result !== wanted_block.left) begin
          $error("left_result: expected %h, actual %h", wanted_block.left, left_result);
          fail_count++;
        end
        if (right_result !== wanted_block.right) begin
          $error("right_result: expected %h, actual %h", wanted_block.right, right_result);
          fail_count++;
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    key_set_t segment_keys [RandomSegments];
    segment_keys = '{KEYS_RANDOM, KEYS_ALTERNATE, KEYS_RANDOM, KEYS_ZERO,
                     KEYS_ONE_HOT, KEYS_RANDOM, KEYS_ONES, KEYS_RANDOM};
    for (int i = 0; i < KeyWords; i++) key_copy[i] = '0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed items under the all-zero key from reset
    send_idle_pct = 26;
    @(negedge clk);
    add_directed_blocks();
    wait_drained();

    // and again under the all-ones key, carries out of every add whose left word is nonzero
    load_key_set(KEYS_ONES);
    @(negedge clk);
    add_directed_blocks();
    wait_drained();

    // random segments, a new key each time; sender idles 26 percent, then 46 percent, then not at all
    for (int seg = 0; seg < RandomSegments; seg++) begin
      if (seg < 3) send_idle_pct = 26;
      else if (seg < 6) send_idle_pct = 46;
      else send_idle_pct = 0;
      load_key_set(segment_keys[seg]);
      @(negedge clk);
      for (int k = 0; k < SegmentItems; k++) begin
        add_block(1'($urandom_range(1)), pick_word(), pick_word());
      end
      wait_drained();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // hard stop if the block hangs
  initial begin
    #2ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/gost_pkg.sv
sv/gost_block_cipher_ecb.sv
test/tb_gost_block_cipher_ecb.sv
